/* rtl/pal_pkg.sv */
`timescale 1ns / 1ps

package pal_pkg;

    // list store size and the widths that follow from it
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // common width for comparing an 8-bit position against the count
    localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;

    localparam int DATA_W   = 32;

    // request kinds
    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_DELETE = 3'd1;
    localparam logic [2:0] REQ_GET    = 3'd2;
    localparam logic [2:0] REQ_LOCATE = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_POS   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [2:0]        status;
        logic [DATA_W-1:0] read_value;
        logic [7:0]        found_index;
        logic [8:0]        length;
    } res_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } ram_req_t;

endpackage

/* rtl/pal_ram.sv */
`timescale 1ns / 1ps

module pal_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/pal_ctrl.sv */
`timescale 1ns / 1ps

module pal_ctrl
    import pal_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // request side
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [2:0]        req_type,
    input  logic [7:0]        position,
    input  logic [DATA_W-1:0] value,
    // result side
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res,
    // store port
    output ram_req_t          ram,
    input  logic [DATA_W-1:0] ram_rd_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UP   = 3'd1;
    localparam logic [2:0] S_DOWN = 3'd2;
    localparam logic [2:0] S_GET  = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    logic              first_reg, first_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [7:0]        pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [2:0]        status_reg, status_next;
    logic [DATA_W-1:0] rd_value_reg, rd_value_next;
    logic [7:0]        idx_reg, idx_next;

    logic [CMP_W-1:0]  pos_in_c, pos_c, cnt_c, ptr_c;

    assign pos_in_c = CMP_W'(position);
    assign pos_c    = CMP_W'(pos_reg);
    assign cnt_c    = CMP_W'(count_reg);
    assign ptr_c    = CMP_W'(ptr_reg);

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    assign res.status      = status_reg;
    assign res.read_value  = rd_value_reg;
    assign res.found_index = idx_reg;
    assign res.length      = 9'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        first_next     = first_reg;
        pend_addr_next = pend_addr_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        status_next    = status_reg;
        rd_value_next  = rd_value_reg;
        idx_next       = idx_reg;
        ram            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    pos_next      = position;
                    val_next      = value;
                    status_next   = ST_OK;
                    rd_value_next = '0;
                    idx_next      = '0;
                    pend_next     = 1'b0;
                    state_next    = S_DONE;
                    unique case (req_type)
                        REQ_INSERT:
                        begin
                            if (pos_in_c > cnt_c)
                            begin
                                status_next = ST_BAD_POS;
                            end
                            else if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                state_next = S_UP;
                            end
                        end
                        REQ_DELETE, REQ_GET:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (pos_in_c >= cnt_c)
                            begin
                                status_next = ST_BAD_POS;
                            end
                            else if (req_type == REQ_GET)
                            begin
                                ram.rd_en   = 1'b1;
                                ram.rd_addr = ADDR_W'(position);
                                state_next  = S_GET;
                            end
                            else
                            begin
                                ptr_next   = CNT_W'(position);
                                state_next = S_DOWN;
                            end
                        end
                        REQ_LOCATE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = ST_BAD_POS;
                        end
                    endcase
                end
            end

            // move entries up from the top end, one read and one write a cycle
            S_UP:
            begin
                if (pend_reg)
                begin
                    ram.wr_en   = 1'b1;
                    ram.wr_addr = pend_addr_reg;
                    ram.wr_data = ram_rd_data;
                end
                if (ptr_c > pos_c)
                begin
                    ram.rd_en      = 1'b1;
                    ram.rd_addr    = ADDR_W'(ptr_reg - 1'b1);
                    ptr_next       = ptr_reg - 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = ADDR_W'(ptr_reg);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        ram.wr_en   = 1'b1;
                        ram.wr_addr = ADDR_W'(pos_reg);
                        ram.wr_data = val_reg;
                        count_next  = count_reg + 1'b1;
                        state_next  = S_DONE;
                    end
                end
            end

            // first read returns the removed word, later ones move down by one
            S_DOWN:
            begin
                if (pend_reg)
                begin
                    if (first_reg)
                    begin
                        rd_value_next = ram_rd_data;
                    end
                    else
                    begin
                        ram.wr_en   = 1'b1;
                        ram.wr_addr = pend_addr_reg - 1'b1;
                        ram.wr_data = ram_rd_data;
                    end
                end
                if (ptr_reg < count_reg)
                begin
                    ram.rd_en      = 1'b1;
                    ram.rd_addr    = ADDR_W'(ptr_reg);
                    ptr_next       = ptr_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = ADDR_W'(ptr_reg);
                    first_next     = (ptr_c == pos_c);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_DONE;
                    end
                end
            end

            S_GET:
            begin
                rd_value_next = ram_rd_data;
                state_next    = S_DONE;
            end

            S_SCAN:
            begin
                if (pend_reg && (ram_rd_data == val_reg))
                begin
                    idx_next   = 8'(pend_addr_reg);
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
                else if (ptr_reg < count_reg)
                begin
                    ram.rd_en      = 1'b1;
                    ram.rd_addr    = ADDR_W'(ptr_reg);
                    ptr_next       = ptr_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = ADDR_W'(ptr_reg);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        first_reg     <= first_next;
        pend_addr_reg <= pend_addr_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        status_reg    <= status_next;
        rd_value_reg  <= rd_value_next;
        idx_reg       <= idx_next;
    end

endmodule

/* rtl/positional_array_list_top.sv */
`timescale 1ns / 1ps

// channel   | group     | tdata (low bit up)                        | tuser
// ----------+-----------+-------------------------------------------+--------------
// request   | s_axis_*  | position[7:0], value[39:8]                | req_type[2:0]
// result    | m_axis_*  | read_value[31:0], found_index[39:32],     | status[2:0]
//           |           | length[48:40], 0 pad to 56                |
//
// one request at a time; a request is taken only when the sequencer is idle
// insert and delete walk the entries from the position to the end of the list, locate
// scans from the front until a hit or the end, get reads one word, and clear or a
// rejected request touches no entry; the single store port, one read and one write a cycle,
// sets the walk length
// reset clears the length and the control state only, store contents are kept
// the result register lets the next request start while a result waits;
// a full result register holds the sequencer at the end of its request

module positional_array_list_top
    import pal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // position[7:0], value[39:8]
    input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // read_value[31:0], found_index[39:32], length[48:40]
    output logic [2:0]  m_axis_tuser    // status[2:0]
);

    ram_req_t          ram;
    logic [DATA_W-1:0] ram_rd_data;
    res_t              res;
    logic              res_valid;
    logic              res_ready;

    // result register
    logic              out_valid_reg;
    res_t              out_reg;

    pal_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_axis_tvalid),
        .req_ready   (s_axis_tready),
        .req_type    (s_axis_tuser),
        .position    (s_axis_tdata[7:0]),
        .value       (s_axis_tdata[39:8]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram         (ram),
        .ram_rd_data (ram_rd_data)
    );

    // list store, one synchronous read and one write port
    pal_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (ram.rd_en),
        .rd_addr (ram.rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram.wr_en),
        .wr_addr (ram.wr_addr),
        .wr_data (ram.wr_data)
    );

    // result register takes a new word when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {7'd0, out_reg.length, out_reg.found_index, out_reg.read_value};

endmodule

/* test/tb_positional_array_list_top.sv */
`timescale 1ns / 1ps

module tb_positional_array_list_top;
    import pal_pkg::*;

    localparam logic [2:0] REQ_KIND_MAX   = 3'd7;  // highest code the tuser field can carry
    localparam int         WATCHDOG_LIMIT = 4000;  // cycles with no word moving on either side
    localparam int         TAIL_CYCLES    = 300;   // longer than the longest walk through the store
    localparam int         RAND_TARGET    = 1030;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  pos;
        logic [31:0] val;
    } list_req_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // position[7:0], value[39:8]
    logic [2:0]  s_axis_tuser  = '0;   // req_type[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;         // read_value[31:0], found_index[39:32], length[48:40]
    logic [2:0]  m_axis_tuser;         // status[2:0]

    // shadow copy of the list, advanced once per accepted request word
    logic [31:0] list_store [CAPACITY];
    int          list_len  = 0;
    int          peak_len  = 0;

    list_req_t   pending_reqs[$];
    res_t        expected_results[$];

    int          reqs_issued   = 0;
    int          reqs_taken    = 0;
    bit          req_taken     = 1'b0;
    int          mismatches    = 0;
    int          stray_results = 0;
    int          idle_cycles   = 0;
    int          rand_sent     = 0;
    int          kind_count   [8];
    int          status_count [8];
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    int          tx_gap   = 0;
    int          rx_stall = 0;

    positional_array_list_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // mostly back to back, some short pauses, now and then a long one
    function automatic int pick_gap(input bit quiet);
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // apply one request to the shadow list and return the result word it should produce
    function automatic res_t apply_request(input list_req_t rq);
        res_t r;
        int   k;
        r        = '0;
        r.status = ST_OK;
        case (rq.kind)
            REQ_INSERT:
            begin
                // position check wins over the full check
                if (int'(rq.pos) > list_len)
                    r.status = ST_BAD_POS;
                else if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (k = list_len; k > int'(rq.pos); k--)
                        list_store[k] = list_store[k - 1];
                    list_store[rq.pos] = rq.val;
                    list_len++;
                end
            end
            REQ_DELETE:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else if (int'(rq.pos) >= list_len)
                    r.status = ST_BAD_POS;
                else
                begin
                    r.read_value = list_store[rq.pos];
                    for (k = int'(rq.pos); k + 1 < list_len; k++)
                        list_store[k] = list_store[k + 1];
                    list_len--;
                end
            end
            REQ_GET:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else if (int'(rq.pos) >= list_len)
                    r.status = ST_BAD_POS;
                else
                    r.read_value = list_store[rq.pos];
            end
            REQ_LOCATE:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.status = ST_NOT_FOUND;
                    for (k = 0; k < list_len && r.status != ST_OK; k++)
                    begin
                        if (list_store[k] == rq.val)
                        begin
                            r.status      = ST_OK;
                            r.found_index = 8'(k);
                        end
                    end
                end
            end
            REQ_CLEAR:
                list_len = 0;
            default:
                r.status = ST_BAD_POS;
        endcase
        if (list_len > peak_len)
            peak_len = list_len;
        r.length = 9'(list_len);
        return r;
    endfunction

    // request driver: holds a word until taken, then pauses or loads the next one
    always @(negedge clk)
    begin : drive_requests
        list_req_t rq;
        if (rst_n)
        begin
            if (!s_axis_tvalid || req_taken)
            begin
                if (tx_gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    tx_gap = tx_gap - 1;
                end
                else if (pending_reqs.size() != 0)
                begin
                    rq = pending_reqs.pop_front();
                    s_axis_tuser  <= rq.kind;
                    s_axis_tdata  <= {rq.val, rq.pos};
                    s_axis_tvalid <= 1'b1;
                    tx_gap = pick_gap(tx_quiet);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_stall > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_stall = rx_stall - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rx_stall = pick_gap(rx_quiet);
            end
        end
    end

    // monitor: predict on each request word taken, check each result word taken
    always @(posedge clk)
    begin : watch_ports
        list_req_t rq;
        res_t      want;
        res_t      got;
        if (rst_n)
        begin
            req_taken = s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                rq.kind = s_axis_tuser;
                rq.pos  = s_axis_tdata[7:0];
                rq.val  = s_axis_tdata[39:8];
                expected_results.push_back(apply_request(rq));
                kind_count[rq.kind]++;
                reqs_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status      = m_axis_tuser;
                got.read_value  = m_axis_tdata[31:0];
                got.found_index = m_axis_tdata[39:32];
                got.length      = m_axis_tdata[48:40];
                status_count[got.status]++;
                if (expected_results.size() == 0)
                begin
                    if (mismatches + stray_results < 10)
                        $display("%0t: result word with none outstanding: status %0d length %0d",
                                 $realtime, got.status, got.length);
                    stray_results++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status || got.read_value != want.read_value ||
                        got.found_index != want.found_index || got.length != want.length)
                    begin
                        if (mismatches + stray_results < 10)
                        begin
                            $display("%0t: expected status %0d value %0d index %0d length %0d",
                                     $realtime, want.status, $signed(want.read_value),
                                     want.found_index, want.length);
                            $display("%0t:      got status %0d value %0d index %0d length %0d",
                                     $realtime, got.status, $signed(got.read_value),
                                     got.found_index, got.length);
                        end
                        mismatches++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial
    begin
        wait (rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // queue one request and wait until the block has taken it, so list_len is current
    task automatic send(input logic [2:0] kind, input logic [7:0] pos, input logic [31:0] val);
        list_req_t rq;
        rq.kind = kind;
        rq.pos  = pos;
        rq.val  = val;
        pending_reqs.push_back(rq);
        reqs_issued++;
        while (reqs_taken != reqs_issued)
        begin
            @(posedge clk);
            #1;
        end
    endtask

    // hold the sender until every result word is back
    task automatic drain();
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
    endtask

    // a small pool of repeats and extremes so locate meets duplicates
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 3) != 0)
            return $urandom;
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h0000_0001;
            5:       return 32'h5A5A_5A5A;
            6:       return 32'hA5A5_A5A5;
            default: return 32'h0000_0007;
        endcase
    endfunction

    function automatic logic [31:0] locate_value();
        if (list_len > 0 && $urandom_range(0, 9) < 6)
            return list_store[$urandom_range(0, list_len - 1)];
        return pick_value();
    endfunction

    // mostly good positions, biased to both ends of the walk, some past the end
    function automatic logic [7:0] pick_position(input logic [2:0] kind);
        int roll;
        int top;
        roll = $urandom_range(0, 99);
        top  = (kind == REQ_INSERT) ? list_len : list_len - 1;
        if (top > 255)
            top = 255;
        if (roll < 6 || top < 0)
            return 8'($urandom_range(0, 255));
        if (roll < 16 && top < 255)
            return 8'($urandom_range(top + 1, 255));
        if (roll < 24)
            return 8'(top);
        if (roll < 30)
            return 8'd0;
        return 8'($urandom_range(0, top));
    endfunction

    task automatic random_request(input int w_ins, input int w_del, input int w_get,
                                  input int w_loc, input int w_clr);
        int         roll;
        logic [2:0] kind;
        roll = $urandom_range(0, w_ins + w_del + w_get + w_loc + w_clr);
        if (roll < w_ins)
            kind = REQ_INSERT;
        else if (roll < w_ins + w_del)
            kind = REQ_DELETE;
        else if (roll < w_ins + w_del + w_get)
            kind = REQ_GET;
        else if (roll < w_ins + w_del + w_get + w_loc)
            kind = REQ_LOCATE;
        else if (roll < w_ins + w_del + w_get + w_loc + w_clr)
            kind = REQ_CLEAR;
        else
            kind = 3'($urandom_range(REQ_CLEAR + 3'd1, REQ_KIND_MAX));
        send(kind, pick_position(kind), (kind == REQ_LOCATE) ? locate_value() : pick_value());
        rand_sent++;
    endtask

    task automatic new_idle_pattern();
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
    endtask

    initial
    begin : stimulus
        int n;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #1;

        // empty list cases, inserts past the end
        send(REQ_GET,    8'd0,   32'h0);
        send(REQ_DELETE, 8'd0,   32'h0);
        send(REQ_LOCATE, 8'd0,   32'h0);
        send(REQ_INSERT, 8'd1,   32'h1234_5678);
        send(REQ_INSERT, 8'd255, 32'hFFFF_FFFF);
        // build min, 0, max, -1 by front, back and middle inserts
        send(REQ_INSERT, 8'd0,   32'h7FFF_FFFF);
        send(REQ_INSERT, 8'd0,   32'h8000_0000);
        send(REQ_INSERT, 8'd2,   32'hFFFF_FFFF);
        send(REQ_INSERT, 8'd1,   32'h0000_0000);
        send(REQ_GET,    8'd3,   32'h0);
        send(REQ_GET,    8'd4,   32'h0);
        send(REQ_GET,    8'd255, 32'hFFFF_FFFF);
        send(REQ_LOCATE, 8'd0,   32'hFFFF_FFFF);
        send(REQ_LOCATE, 8'd0,   32'h0000_3039);
        // duplicate value: locate must report the first copy
        send(REQ_INSERT, 8'd1,   32'hFFFF_FFFF);
        send(REQ_LOCATE, 8'd255, 32'hFFFF_FFFF);
        send(REQ_DELETE, 8'd5,   32'h0);
        send(REQ_DELETE, 8'd0,   32'h0);
        send(REQ_DELETE, 8'd3,   32'h0);
        // unused request codes leave the list alone
        send(REQ_CLEAR + 3'd1, 8'd0,   32'h0);
        send(REQ_CLEAR + 3'd2, 8'd255, 32'hFFFF_FFFF);
        send(REQ_KIND_MAX,     8'd1,   32'h0);
        send(REQ_CLEAR,        8'd0,   32'h0);
        send(REQ_GET,          8'd0,   32'h0);
        send(REQ_CLEAR,        8'd0,   32'h0);

        // fill to capacity with mostly inserts
        drain();
        new_idle_pattern();
        n = 0;
        while (list_len < CAPACITY && n < 520)
        begin
            random_request(78, 4, 8, 8, 0);
            n++;
        end

        // hover at full, no idling on either side
        drain();
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        for (n = 0; n < 50; n++)
            random_request(50, 10, 20, 20, 0);

        // empty it again, then a few requests on the empty list
        drain();
        new_idle_pattern();
        n = 0;
        while (list_len > 0 && n < 450)
        begin
            random_request(5, 75, 10, 10, 0);
            n++;
        end
        for (n = 0; n < 10; n++)
            random_request(20, 30, 20, 20, 0);

        // balanced mix with clears, sender held until drained every hundred words
        n = 0;
        while (rand_sent < RAND_TARGET)
        begin
            if (n % 100 == 0)
            begin
                drain();
                new_idle_pattern();
            end
            random_request(30, 25, 20, 20, 3);
            n++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("requests: %0d insert, %0d delete, %0d get, %0d locate, %0d clear, %0d unused",
                 kind_count[REQ_INSERT], kind_count[REQ_DELETE], kind_count[REQ_GET],
                 kind_count[REQ_LOCATE], kind_count[REQ_CLEAR],
                 kind_count[5] + kind_count[6] + kind_count[7]);
        $display("results: %0d ok, %0d bad position, %0d full, %0d empty, %0d not found, %s %0d",
                 status_count[ST_OK], status_count[ST_BAD_POS], status_count[ST_FULL],
                 status_count[ST_EMPTY], status_count[ST_NOT_FOUND], "peak length", peak_len);
        if (mismatches == 0 && stray_results == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
rtl/pal_pkg.sv
rtl/pal_ram.sv
rtl/pal_ctrl.sv
rtl/positional_array_list_top.sv
test/tb_positional_array_list_top.sv
